// ----- hw/rtl/allocation_bitmap_engine_assert.svh -----
// Assertion macros shared by the allocation bitmap engine RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ALLOCATION_BITMAP_ENGINE_ASSERT_SVH
`define ALLOCATION_BITMAP_ENGINE_ASSERT_SVH

// checked outside reset only
`define ABE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ABE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/abe_pkg.sv -----
// Shared types and constants of the allocation bitmap engine.
// No dependencies.
package abe_pkg;

  localparam int CMD_IDX_W  = 13;
  localparam int CMD_WORD_W = 10;
  localparam int CMD_OFS_W  = 6;

  typedef enum logic [2:0] {
    OP_SET_BIT   = 3'd0,
    OP_CLR_BIT   = 3'd1,
    OP_READ_BIT  = 3'd2,
    OP_SET_RANGE = 3'd3,
    OP_CLR_RANGE = 3'd4,
    OP_FILL_ALL  = 3'd5
  } abe_op_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_SET_BIT,
    KIND_CLR_BIT,
    KIND_READ_BIT,
    KIND_RANGE,
    KIND_FILL
  } abe_kind_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_MODIFY,
    ST_FILL
  } abe_state_t;

  typedef struct packed {
    abe_kind_t             kind;
    logic                  status;
    logic                  value;
    logic [CMD_WORD_W-1:0] first_word;
    logic [CMD_WORD_W-1:0] last_word;
    logic [CMD_OFS_W-1:0]  lo;
    logic [CMD_OFS_W-1:0]  hi;
  } abe_cmd_t;

  typedef struct packed {
    logic bit_value;
    logic status;
  } abe_result_t;

endpackage

// ----- hw/rtl/abe_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module abe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/abe_queue.sv -----
// Small register-based FIFO used between the engine's parts and at its output.
// No dependencies.
module abe_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/abe_front.sv -----
// Front end: accepts request words, checks bounds, splits bit indexes into word and offset.
// Depends on abe_pkg and allocation_bitmap_engine_assert.svh.
`include "allocation_bitmap_engine_assert.svh"

module abe_front #(
  parameter int unsigned NUM_BITS  = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_op,
  input  logic [11:0]       in_bit_index,
  input  logic [12:0]       in_end_index,
  input  logic              in_fill_value,
  input  logic              hold,
  output logic              cmd_push,
  output abe_pkg::abe_cmd_t cmd,
  input  logic              cmd_full
);

  localparam int unsigned IW       = abe_pkg::CMD_IDX_W;
  localparam int unsigned QW       = abe_pkg::CMD_WORD_W;
  localparam int unsigned DIV_L    = $clog2(WORD_BITS);
  localparam int unsigned DIV_K    = IW + DIV_L;
  localparam int unsigned PROD_W   = IW + IW + 2;
  localparam int unsigned DIV_M_IN = (2 ** DIV_K + WORD_BITS - 1) / WORD_BITS;
  localparam logic [PROD_W-1:0] DIV_M = PROD_W'(DIV_M_IN);
  localparam logic [IW-1:0]     WB    = IW'(WORD_BITS);

  typedef struct packed {
    abe_pkg::abe_kind_t kind;
    logic               status;
    logic               value;
    logic [IW-1:0]      x0;
    logic [IW-1:0]      x1;
    logic [QW-1:0]      q0;
    logic [QW-1:0]      q1;
  } abe_stage_t;

  function automatic logic [QW-1:0] word_of(input logic [IW-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * DIV_M;
    return QW'(p >> DIV_K);
  endfunction

  abe_stage_t    s1_r, s1_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic          accept;
  logic          idx_bad, end_bad, range_live;
  logic [IW-1:0] rem0, rem1;

  assign in_full  = hold || (s1_v_r && cmd_full);
  assign accept   = in_push && !in_full;
  assign cmd_push = s1_v_r && !cmd_full;
  assign s1_v_nxt = accept || (s1_v_r && cmd_full);

  assign idx_bad    = 32'(in_bit_index) >= NUM_BITS;
  assign end_bad    = 32'(in_end_index) > NUM_BITS;
  assign range_live = IW'(in_bit_index) < in_end_index;

  always_comb begin
    s1_nxt.kind   = abe_pkg::KIND_NONE;
    s1_nxt.status = 1'b0;
    s1_nxt.value  = 1'b0;
    s1_nxt.x0     = IW'(in_bit_index);
    s1_nxt.x1     = in_end_index - IW'(1);
    s1_nxt.q0     = word_of(s1_nxt.x0);
    s1_nxt.q1     = word_of(s1_nxt.x1);
    unique case (abe_pkg::abe_op_t'(in_op))
      abe_pkg::OP_SET_BIT: begin
        s1_nxt.status = idx_bad;
        s1_nxt.kind   = idx_bad ? abe_pkg::KIND_NONE : abe_pkg::KIND_SET_BIT;
      end
      abe_pkg::OP_CLR_BIT: begin
        s1_nxt.status = idx_bad;
        s1_nxt.kind   = idx_bad ? abe_pkg::KIND_NONE : abe_pkg::KIND_CLR_BIT;
      end
      abe_pkg::OP_READ_BIT: begin
        s1_nxt.status = idx_bad;
        s1_nxt.kind   = idx_bad ? abe_pkg::KIND_NONE : abe_pkg::KIND_READ_BIT;
      end
      abe_pkg::OP_SET_RANGE, abe_pkg::OP_CLR_RANGE: begin
        s1_nxt.status = end_bad;
        s1_nxt.value  = (abe_pkg::abe_op_t'(in_op) == abe_pkg::OP_SET_RANGE);
        s1_nxt.kind   = (!end_bad && range_live) ? abe_pkg::KIND_RANGE : abe_pkg::KIND_NONE;
      end
      abe_pkg::OP_FILL_ALL: begin
        s1_nxt.kind  = abe_pkg::KIND_FILL;
        s1_nxt.value = in_fill_value;
      end
      default: begin
        s1_nxt.kind = abe_pkg::KIND_NONE;
      end
    endcase
  end

  // offsets from the registered word numbers
  assign rem0 = s1_r.x0 - IW'(s1_r.q0) * WB;
  assign rem1 = s1_r.x1 - IW'(s1_r.q1) * WB;

  always_comb begin
    cmd.kind       = s1_r.kind;
    cmd.status     = s1_r.status;
    cmd.value      = s1_r.value;
    cmd.first_word = s1_r.q0;
    cmd.last_word  = s1_r.q1;
    cmd.lo         = abe_pkg::CMD_OFS_W'(rem0);
    cmd.hi         = abe_pkg::CMD_OFS_W'(rem1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  `ABE_ASSERT(a_stage_holds, (s1_v_r && cmd_full) |=> (s1_v_r && $stable(s1_r)), "front stage lost a stalled word")
  `ABE_ASSERT(a_hold_blocks, hold |-> in_full, "word accepted while map clears")

endmodule

// ----- hw/rtl/abe_back.sv -----
// Back end: executes commands on the word RAM (read-modify-write, range walk, fill).
// Depends on abe_pkg, abe_ram and allocation_bitmap_engine_assert.svh.
`include "allocation_bitmap_engine_assert.svh"

module abe_back #(
  parameter int unsigned NUM_BITS  = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  abe_pkg::abe_cmd_t    cmd,
  input  logic                 res_full,
  output logic                 res_push,
  output abe_pkg::abe_result_t res,
  output logic                 init_busy
);

  localparam int unsigned MAP_DEPTH = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned LAST_BITS = NUM_BITS - (MAP_DEPTH - 1) * WORD_BITS;
  localparam int unsigned OW        = abe_pkg::CMD_OFS_W;
  localparam logic [AW-1:0]        LAST_ADDR = AW'(MAP_DEPTH - 1);
  localparam logic [WORD_BITS-1:0] ALL_ONES  = '1;
  localparam logic [WORD_BITS-1:0] ONE_BIT   = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] TAIL_MASK = ALL_ONES >> (WORD_BITS - LAST_BITS);
  localparam logic [OW-1:0]        TOP_OFS   = OW'(WORD_BITS - 1);

  function automatic logic [AW-1:0] to_addr(input logic [abe_pkg::CMD_WORD_W-1:0] w);
    return AW'(w);
  endfunction

  abe_pkg::abe_state_t state_r, state_nxt;
  abe_pkg::abe_cmd_t   cmd_r, cmd_nxt;
  logic [AW-1:0]       walk_r, walk_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [WORD_BITS-1:0] mask;
  logic [OW-1:0]        lo_eff, hi_eff;
  logic                 at_last;

  abe_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_busy = (state_r == abe_pkg::ST_INIT);
  assign at_last   = (walk_r == to_addr(cmd_r.last_word));
  assign lo_eff    = (walk_r == to_addr(cmd_r.first_word)) ? cmd_r.lo : '0;
  assign hi_eff    = at_last ? cmd_r.hi : TOP_OFS;

  always_comb begin
    if (cmd_r.kind == abe_pkg::KIND_RANGE) begin
      mask = (ALL_ONES >> (TOP_OFS - hi_eff)) & (ALL_ONES << lo_eff);
    end else begin
      mask = ONE_BIT << cmd_r.lo;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    walk_nxt      = walk_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res.bit_value = 1'b0;
    res.status    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = walk_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = walk_r;
    unique case (state_r)
      abe_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (walk_r == LAST_ADDR) begin
          walk_nxt  = '0;
          state_nxt = abe_pkg::ST_IDLE;
        end else begin
          walk_nxt = walk_r + AW'(1);
        end
      end
      abe_pkg::ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          unique case (cmd.kind)
            abe_pkg::KIND_NONE: begin
              res_push   = 1'b1;
              res.status = cmd.status;
            end
            abe_pkg::KIND_FILL: begin
              walk_nxt  = '0;
              state_nxt = abe_pkg::ST_FILL;
            end
            default: begin
              ram_raddr = to_addr(cmd.first_word);
              walk_nxt  = to_addr(cmd.first_word);
              state_nxt = abe_pkg::ST_MODIFY;
            end
          endcase
        end
      end
      abe_pkg::ST_MODIFY: begin
        unique case (cmd_r.kind)
          abe_pkg::KIND_READ_BIT: begin
            res_push      = 1'b1;
            res.bit_value = |(ram_rdata & mask);
            state_nxt     = abe_pkg::ST_IDLE;
          end
          abe_pkg::KIND_SET_BIT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | mask;
            res_push  = 1'b1;
            state_nxt = abe_pkg::ST_IDLE;
          end
          abe_pkg::KIND_CLR_BIT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~mask;
            res_push  = 1'b1;
            state_nxt = abe_pkg::ST_IDLE;
          end
          abe_pkg::KIND_RANGE: begin
            ram_we    = 1'b1;
            ram_wdata = cmd_r.value ? (ram_rdata | mask) : (ram_rdata & ~mask);
            if (at_last) begin
              res_push  = 1'b1;
              state_nxt = abe_pkg::ST_IDLE;
            end else begin
              // next word is read while this one is written
              walk_nxt  = walk_r + AW'(1);
              ram_raddr = walk_r + AW'(1);
            end
          end
          default: begin
            state_nxt = abe_pkg::ST_IDLE;
          end
        endcase
      end
      abe_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = cmd_r.value ? ((walk_r == LAST_ADDR) ? TAIL_MASK : ALL_ONES) : '0;
        if (walk_r == LAST_ADDR) begin
          walk_nxt  = '0;
          res_push  = 1'b1;
          state_nxt = abe_pkg::ST_IDLE;
        end else begin
          walk_nxt = walk_r + AW'(1);
        end
      end
      default: begin
        state_nxt = abe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abe_pkg::ST_INIT;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  `ABE_ASSERT(a_res_room, res_push |-> !res_full, "result pushed into a full queue")
  `ABE_ASSERT(a_pop_idle, cmd_pop |-> (state_r == abe_pkg::ST_IDLE && !cmd_empty), "command taken while busy")
  `ABE_ASSERT(a_init_done, $fell(init_busy) |-> ($past(walk_r) == LAST_ADDR), "clearing pass cut short")
  `ABE_ASSERT_ALWAYS(a_read_no_write, (state_r == abe_pkg::ST_MODIFY && cmd_r.kind == abe_pkg::KIND_READ_BIT) |-> !ram_we, "bit read wrote the map")

endmodule

// ----- hw/rtl/allocation_bitmap_engine.sv -----
// Allocation bitmap engine: NUM_BITS-bit map kept as WORD_BITS-bit words in a RAM.
// Requests enter on a queue-style port (in_push / in_full); one result word per request
// leaves on a queue-style port (out_empty / out_pop), oldest first.
// Ops: set, clear, read one bit; set or clear [bit_index, end_index); fill all.
// A bit request's result reaches the out ports through the front stage, the command queue,
// a RAM read as the command is taken, and the modify step; a request that needs no RAM
// access skips the read and modify, and ranges and fill take longer.
// The back end, with its single RAM write port, finishes one command before it takes the next:
//   bad index, bad end, empty range, unused op: result pushed as the command is taken
//   set, clear or read bit: registered RAM read, then write (set, clear) or result (read)
//   range over N words: first word read as taken, then one word written per cycle
//   fill all: every one of the MAP_DEPTH words written (128 at the default size)
// Reset (rst_n low, synchronous) starts a clearing pass over all MAP_DEPTH words (128 at
// the default size) during which in_full stays high.
// When the receiver stops popping, up to two results wait in the output queue, then the
// back end stops, the command queue fills and in_full rises; nothing is dropped.
// Depends on abe_pkg, abe_queue, abe_front, abe_back, abe_ram.
module allocation_bitmap_engine #(
  parameter int unsigned NUM_BITS  = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_op,
  input  logic [11:0] in_bit_index,
  input  logic [12:0] in_end_index,
  input  logic        in_fill_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_bit_value,
  output logic        out_status
);

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned CMD_W     = $bits(abe_pkg::abe_cmd_t);
  localparam int unsigned RES_W     = $bits(abe_pkg::abe_result_t);

  abe_pkg::abe_cmd_t    front_cmd, back_cmd;
  abe_pkg::abe_result_t back_res, out_res;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;
  logic init_busy;

  abe_front #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_bit_index  (in_bit_index),
    .in_end_index  (in_end_index),
    .in_fill_value (in_fill_value),
    .hold          (init_busy),
    .cmd_push      (cmd_push),
    .cmd           (front_cmd),
    .cmd_full      (cmd_full)
  );

  abe_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .empty     (cmd_empty)
  );

  abe_back #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (back_cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res),
    .init_busy (init_busy)
  );

  abe_queue #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (back_res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_res),
    .empty     (out_empty)
  );

  assign out_bit_value = out_res.bit_value;
  assign out_status    = out_res.status;

endmodule
